@@ rtl/jdptm_pkg.sv @@
// Shared types and constants for the joystick drive and pan/tilt mapper.
`timescale 1ns / 1ps

package jdptm_pkg;

  // Event type codes.
  localparam logic [7:0] KIND_BUTTON = 8'd1;
  localparam logic [7:0] KIND_AXIS   = 8'd2;

  // Button numbers.
  localparam logic [7:0] BTN_LAMP  = 8'd0;
  localparam logic [7:0] BTN_STORE = 8'd2;
  localparam logic [7:0] BTN_POWER = 8'd8;
  localparam logic [7:0] BTN_HOME  = 8'd9;

  // Axis numbers.
  localparam logic [7:0] AXIS_PAN    = 8'd0;
  localparam logic [7:0] AXIS_TILT   = 8'd1;
  localparam logic [7:0] AXIS_TURN   = 8'd2;
  localparam logic [7:0] AXIS_TRAVEL = 8'd3;

  // Status byte bit masks.
  localparam logic [7:0] BIT_POWER     = 8'h03;
  localparam logic [7:0] BIT_LIGHT     = 8'h04;
  localparam logic [7:0] BIT_LEFT_NEG  = 8'h80;
  localparam logic [7:0] BIT_RIGHT_NEG = 8'h40;

  // Camera home positions after reset.
  localparam logic [15:0] PAN_HOME_RESET  = 16'd1500;
  localparam logic [15:0] TILT_HOME_RESET = 16'd1560;

  // Input item.
  typedef struct packed {
    logic [7:0]         kind;
    logic [7:0]         number;
    logic signed [15:0] value;
    logic [7:0]         status_in;
  } jdptm_in_t;

  // Result item.
  typedef struct packed {
    logic [7:0]         status_out;
    logic               left_update;
    logic [8:0]         left_magnitude;
    logic               right_update;
    logic [8:0]         right_magnitude;
    logic               pan_update;
    logic signed [15:0] pan_position;
    logic               tilt_update;
    logic signed [15:0] tilt_position;
  } jdptm_out_t;

  // Persistent mapper state.
  typedef struct packed {
    logic [15:0]        pan_home_pos;
    logic [15:0]        tilt_home_pos;
    logic [15:0]        pan_now;
    logic [15:0]        tilt_now;
    logic signed [3:0]  pan_rate;
    logic signed [3:0]  tilt_rate;
    logic signed [7:0]  travel_rate;
    logic signed [7:0]  turn_rate;
    logic               power_button_level;
    logic               home_button_level;
    logic               lamp_lit;
    logic               lamp_phase;
    logic signed [8:0]  last_left;
    logic signed [8:0]  last_right;
  } jdptm_state_t;

endpackage

@@ rtl/jdptm_step.sv @@
// Combinational event decode, drive mixing and camera stepping for one item.
`timescale 1ns / 1ps

module jdptm_step import jdptm_pkg::*; (
  input  jdptm_state_t state_cur,
  input  jdptm_in_t    item,
  output jdptm_state_t state_nxt,
  output jdptm_out_t   result
);

  always_comb begin
    jdptm_state_t      st;
    logic [7:0]        status;
    logic              low_nonzero;
    logic              value_one;
    logic signed [8:0] left;
    logic signed [8:0] right;
    logic              lu;
    logic              ru;
    logic              pu;
    logic              tu;

    st          = state_cur;
    status      = item.status_in;
    low_nonzero = |item.value[7:0];
    value_one   = (item.value == 16'sd1);

    // Event decode: buttons and axes update the stored state.
    case (item.kind)
      KIND_BUTTON: begin
        case (item.number)
          BTN_LAMP: begin
            if (!st.lamp_phase) begin
              st.lamp_lit = !st.lamp_lit;
            end
            st.lamp_phase = !st.lamp_phase;
          end
          BTN_POWER: begin
            if (!st.power_button_level && value_one) begin
              status = status ^ BIT_POWER;
            end
            st.power_button_level = low_nonzero;
          end
          BTN_HOME: begin
            if (!st.home_button_level && value_one) begin
              st.pan_now   = st.pan_home_pos;
              st.tilt_now  = st.tilt_home_pos;
              st.pan_rate  = 4'sd0;
              st.tilt_rate = 4'sd0;
            end
            st.home_button_level = low_nonzero;
          end
          BTN_STORE: begin
            if (value_one) begin
              st.pan_home_pos  = st.pan_now;
              st.tilt_home_pos = st.tilt_now;
            end
          end
          default: begin
          end
        endcase
      end
      KIND_AXIS: begin
        case (item.number)
          AXIS_TRAVEL: st.travel_rate = item.value[15:8];
          AXIS_TURN:   st.turn_rate   = item.value[15:8];
          AXIS_PAN:    st.pan_rate    = item.value[15:12];
          AXIS_TILT:   st.tilt_rate   = item.value[15:12];
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    // Mix travel and turn into wheel speeds and set the direction bits.
    left  = {st.travel_rate[7], st.travel_rate} + {st.turn_rate[7], st.turn_rate};
    right = {st.travel_rate[7], st.travel_rate} - {st.turn_rate[7], st.turn_rate};
    status[7] = left[8];
    status[6] = right[8];

    lu = (left != st.last_left);
    ru = (right != st.last_right);
    st.last_left  = left;
    st.last_right = right;

    // Step the camera positions by their rates, wrapping in 16 bits.
    pu = (st.pan_rate != 4'sd0);
    tu = (st.tilt_rate != 4'sd0);
    st.pan_now  = st.pan_now - {{12{st.pan_rate[3]}}, st.pan_rate};
    st.tilt_now = st.tilt_now - {{12{st.tilt_rate[3]}}, st.tilt_rate};

    if (st.lamp_lit) begin
      status = status ^ BIT_LIGHT;
    end

    // Assemble the result; a 9-bit negate of -256 yields 256 as unsigned.
    state_nxt              = st;
    result.status_out      = status;
    result.left_update     = lu;
    result.left_magnitude  = lu ? (left[8] ? 9'(-left) : 9'(left)) : 9'd0;
    result.right_update    = ru;
    result.right_magnitude = ru ? (right[8] ? 9'(-right) : 9'(right)) : 9'd0;
    result.pan_update      = pu;
    result.pan_position    = $signed(st.pan_now);
    result.tilt_update     = tu;
    result.tilt_position   = $signed(st.tilt_now);
  end

endmodule

@@ rtl/joystick_drive_pan_tilt_mapper.sv @@
// Top level of the joystick drive and pan/tilt mapper with its item registers.
// An item taken is held in the input register, and its result is then
// registered in the output register until the out side takes it.
// Throughput: one item per cycle; while a result is stalled the empty input
// register still takes one item, then the input stalls with the output.
// Reset: synchronous, active low; clears valids and restores the camera home
// and current positions, rates, button levels, lamp state and last wheel speeds.
`timescale 1ns / 1ps

module joystick_drive_pan_tilt_mapper import jdptm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  jdptm_in_t  in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output jdptm_out_t out_item
);

  logic         in_valid_r;
  jdptm_in_t    in_item_r;
  logic         out_valid_r;
  jdptm_out_t   out_item_r;
  jdptm_state_t state_r;
  jdptm_state_t state_nxt;
  jdptm_out_t   result_nxt;
  logic         advance;
  logic         fire;

  // The result register frees when empty or when its item is taken.
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  jdptm_step u_step (
    .state_cur (state_r),
    .item      (in_item_r),
    .state_nxt (state_nxt),
    .result    (result_nxt)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
  end

  // Result register and mapper state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r                <= 1'b0;
      state_r.pan_home_pos       <= PAN_HOME_RESET;
      state_r.tilt_home_pos      <= TILT_HOME_RESET;
      state_r.pan_now            <= PAN_HOME_RESET;
      state_r.tilt_now           <= TILT_HOME_RESET;
      state_r.pan_rate           <= 4'sd0;
      state_r.tilt_rate          <= 4'sd0;
      state_r.travel_rate        <= 8'sd0;
      state_r.turn_rate          <= 8'sd0;
      state_r.power_button_level <= 1'b0;
      state_r.home_button_level  <= 1'b0;
      state_r.lamp_lit           <= 1'b0;
      state_r.lamp_phase         <= 1'b0;
      state_r.last_left          <= 9'sd0;
      state_r.last_right         <= 9'sd0;
    end else begin
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      if (fire) begin
        state_r <= state_nxt;
      end
    end
    if (fire) begin
      out_item_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A buffered item moves into an empty result register on the next edge.
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("buffered item did not reach the result register");

  // Magnitudes are only reported alongside their update flags.
  a_left_mag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.left_update) |-> (out_item_r.left_magnitude == 9'd0))
    else $error("left magnitude without update");

  a_right_mag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.right_update) |-> (out_item_r.right_magnitude == 9'd0))
    else $error("right magnitude without update");

  // State changes only when an item is processed.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(state_r))
    else $error("state changed without an item");

endmodule
